[rtl/core/omni_camera_point_projection_defines.svh]
// Assertion helpers for the point projection pipeline
`ifndef OMNI_CAMERA_POINT_PROJECTION_DEFINES_SVH
`define OMNI_CAMERA_POINT_PROJECTION_DEFINES_SVH

// Check that a condition implies a consequence on the same edge
`define OCP_ASSERT_IMP(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence on the next edge
`define OCP_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/ocp_pkg.sv]
package ocp_pkg;

    localparam int IMAGE_WIDTH  = 1024;
    localparam int IMAGE_HEIGHT = 1024;

    // Square-root pipeline: one result bit per stage
    localparam int SQRT_BITS = 32;
    // Divider pipeline: one quotient bit per stage
    localparam int DIV_BITS  = 58;
    // Denominator magnitude: z plus xi times the norm stays below 2^40
    localparam int DEN_BITS  = 40;
    // Distortion and pixel stages
    localparam int DIST_STAGES = 12;
    // Both bit-per-stage units add one load register in front of their stages
    localparam int LATENCY = 2 + (SQRT_BITS + 1) + 2 + (DIV_BITS + 1) + 1 + DIST_STAGES;

    localparam logic [2:0] REG_FOCAL_X    = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y    = 3'd1;
    localparam logic [2:0] REG_CENTER_X   = 3'd2;
    localparam logic [2:0] REG_CENTER_Y   = 3'd3;
    localparam logic [2:0] REG_MIRROR_XI  = 3'd4;
    localparam logic [2:0] REG_RADIAL_K1  = 3'd5;
    localparam logic [2:0] REG_RADIAL_K2  = 3'd6;
    localparam logic [2:0] REG_TANGENTIAL = 3'd7;

    // Signed denominator, one bit above its magnitude
    typedef logic signed [DEN_BITS:0] t_den;

    typedef struct packed {
        logic [31:0] focal_x;
        logic [31:0] focal_y;
        logic [31:0] center_x;
        logic [31:0] center_y;
        logic signed [31:0] xi;
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } t_cfg;

    // Flags that ride along with a point
    typedef struct packed {
        logic behind;
        logic zero_den;
        logic sgn_x;
        logic sgn_y;
    } t_flags;

    // Saturate a 66 bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -66'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q8.24 product floored (arithmetic shift), saturated
    function automatic logic signed [31:0] qmul_sat(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> 24;
        return sat32({{2{s[63]}}, s});
    endfunction

endpackage

[rtl/core/omni_camera_point_projection.sv]
// Projects one camera-frame point per clock through the unified omnidirectional
// model with radial-tangential distortion. A point is taken at every edge where
// start is high and busy is low; busy is always low, so one point may enter in
// every cycle. Each result appears on o_pixel_u/o_pixel_v/o_in_front/o_in_image
// for exactly one cycle with o_done high, in the order of its point; the receiver
// cannot stall, so it must take every word. Most of the pipeline depth lies in the
// bit-per-stage square root (32 stages plus a load stage) and the bit-per-stage
// divider (58 stages plus a load stage). Write configuration only while idle.
module omni_camera_point_projection
    import ocp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    input  logic signed [31:0]  i_point_x,
    input  logic signed [31:0]  i_point_y,
    input  logic signed [31:0]  i_point_z,
    output logic                o_done,
    output logic signed [31:0]  o_pixel_u,
    output logic signed [31:0]  o_pixel_v,
    output logic                o_in_front,
    output logic                o_in_image
);
`include "omni_camera_point_projection_defines.svh"

    t_cfg r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{focal_x: 32'h0001_0000, focal_y: 32'h0001_0000, default: '0};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FOCAL_X:    r_cfg.focal_x  <= i_cfg_data[31:0];
                REG_FOCAL_Y:    r_cfg.focal_y  <= i_cfg_data[31:0];
                REG_CENTER_X:   r_cfg.center_x <= i_cfg_data[31:0];
                REG_CENTER_Y:   r_cfg.center_y <= i_cfg_data[31:0];
                REG_MIRROR_XI:  r_cfg.xi       <= i_cfg_data[31:0];
                REG_RADIAL_K1:  r_cfg.k1       <= i_cfg_data[31:0];
                REG_RADIAL_K2:  r_cfg.k2       <= i_cfg_data[31:0];
                REG_TANGENTIAL: begin
                    r_cfg.p1 <= i_cfg_data[31:0];
                    r_cfg.p2 <= i_cfg_data[63:32];
                end
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;
    logic w_acc;
    assign w_acc = start && !busy;

    // Stage A: squares
    logic               r_va;
    logic signed [31:0] r_xa, r_ya, r_za;
    logic [63:0]        r_sxa, r_sya, r_sza;
    always_ff @(posedge i_clk) begin
        r_xa  <= i_point_x;
        r_ya  <= i_point_y;
        r_za  <= i_point_z;
        r_sxa <= 64'(i_point_x * i_point_x);
        r_sya <= 64'(i_point_y * i_point_y);
        r_sza <= 64'(i_point_z * i_point_z);
        if (!i_rst_n) r_va <= 1'b0;
        else          r_va <= w_acc;
    end

    // Stage B: sum of squares
    logic        r_vb;
    logic [63:0] r_sqb;
    logic [95:0] r_pb;
    always_ff @(posedge i_clk) begin
        r_sqb <= r_sxa + r_sya + r_sza;
        r_pb  <= {r_xa, r_ya, r_za};
        if (!i_rst_n) r_vb <= 1'b0;
        else          r_vb <= r_va;
    end

    logic                 w_vs;
    logic [SQRT_BITS-1:0] w_root;
    logic [95:0]          w_ps;
    ocp_sqrt u_sqrt (
        .i_clk, .i_rst_n,
        .i_valid(r_vb), .i_rad(r_sqb), .i_side(r_pb),
        .o_valid(w_vs), .o_root(w_root), .o_side(w_ps)
    );

    // Stage C: xi times norm
    logic               r_vc;
    logic signed [63:0] r_xin;
    logic [95:0]        r_pc;
    always_ff @(posedge i_clk) begin
        r_xin <= r_cfg.xi * $signed({1'b0, w_root});
        r_pc  <= w_ps;
        if (!i_rst_n) r_vc <= 1'b0;
        else          r_vc <= w_vs;
    end

    // Stage D: denominator, magnitudes and flags
    logic signed [31:0] w_xc, w_yc, w_zc;
    t_den               w_den;
    assign w_xc  = r_pc[95:64];
    assign w_yc  = r_pc[63:32];
    assign w_zc  = r_pc[31:0];
    assign w_den = t_den'(w_zc) + t_den'(r_xin >>> 24);

    logic                r_vd;
    logic [DIV_BITS-1:0] r_nx, r_ny;
    logic [DEN_BITS-1:0] r_dd;
    logic [3:0]          r_td;
    logic [1:0]          r_sd;
    always_ff @(posedge i_clk) begin
        r_nx <= DIV_BITS'({w_xc[31] ? 32'(-w_xc) : w_xc, 24'b0});
        r_ny <= DIV_BITS'({w_yc[31] ? 32'(-w_yc) : w_yc, 24'b0});
        r_dd <= w_den[DEN_BITS] ? DEN_BITS'(-w_den) : DEN_BITS'(w_den);
        r_td <= {w_zc[31], w_den == '0, w_xc[31], w_yc[31]};
        r_sd <= {w_xc[31] ^ w_den[DEN_BITS], w_yc[31] ^ w_den[DEN_BITS]};
        if (!i_rst_n) r_vd <= 1'b0;
        else          r_vd <= r_vc;
    end

    logic                w_vq;
    logic [DIV_BITS-1:0] w_qx, w_qy;
    logic [3:0]          w_tq;
    logic [1:0]          r_sq [DIV_BITS+1];
    always_ff @(posedge i_clk) begin
        r_sq[0] <= r_sd;
        for (int i = 1; i <= DIV_BITS; i++) r_sq[i] <= r_sq[i-1];
    end
    ocp_div u_div (
        .i_clk, .i_rst_n,
        .i_valid(r_vd), .i_num_x(r_nx), .i_num_y(r_ny), .i_den(r_dd), .i_tag(r_td),
        .o_valid(w_vq), .o_quo_x(w_qx), .o_quo_y(w_qy), .o_tag(w_tq)
    );

    // Stage E: apply sign and saturate normalized point
    logic               r_ve;
    logic signed [31:0] r_mx, r_my;
    t_flags             r_fe;
    always_ff @(posedge i_clk) begin
        r_mx <= sat32(r_sq[DIV_BITS][1] ? -$signed({8'b0, w_qx}) : $signed({8'b0, w_qx}));
        r_my <= sat32(r_sq[DIV_BITS][0] ? -$signed({8'b0, w_qy}) : $signed({8'b0, w_qy}));
        r_fe <= '{behind: w_tq[3], zero_den: w_tq[2], sgn_x: w_tq[1], sgn_y: w_tq[0]};
        if (!i_rst_n) r_ve <= 1'b0;
        else          r_ve <= w_vq;
    end

    ocp_distort u_dist (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_valid(r_ve), .i_mx(r_mx), .i_my(r_my), .i_flags(r_fe),
        .o_valid(o_done), .o_u(o_pixel_u), .o_v(o_pixel_v),
        .o_front(o_in_front), .o_image(o_in_image)
    );

    `OCP_ASSERT_IMP(a_behind_zero, i_clk, i_rst_n, o_done && !o_in_front,
        o_pixel_u == '0 && o_pixel_v == '0 && !o_in_image)
    `OCP_ASSERT_IMP(a_image_front, i_clk, i_rst_n, o_done && o_in_image, o_in_front)
    `OCP_ASSERT_NEXT(a_stage_a, i_clk, i_rst_n, w_acc, r_va)
endmodule

[rtl/core/ocp_sqrt.sv]
// Pipelined restoring square root, one result bit per stage
module ocp_sqrt
    import ocp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [63:0]              i_rad,
    input  logic [95:0]              i_side,
    output logic                     o_valid,
    output logic [SQRT_BITS-1:0]     o_root,
    output logic [95:0]              o_side
);
    logic [SQRT_BITS:0]      r_vld;
    logic [63:0]             r_rem  [SQRT_BITS+1];
    logic [SQRT_BITS-1:0]    r_root [SQRT_BITS+1];
    logic [63:0]             r_src  [SQRT_BITS+1];
    logic [95:0]             r_side [SQRT_BITS+1];

    // Load the radicand
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_src[0]  <= i_rad;
        r_side[0] <= i_side;
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    // Each stage takes two radicand bits and decides one root bit
    for (genvar g = 0; g < SQRT_BITS; g++) begin : g_stage
        logic [65:0] n_trial;
        logic [65:0] n_rem2;
        always_comb begin
            n_rem2  = {r_rem[g], r_src[g][63:62]};
            n_trial = {32'b0, r_root[g], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            r_src[g+1]  <= {r_src[g][61:0], 2'b00};
            r_side[g+1] <= r_side[g];
            if (n_rem2 >= n_trial) begin
                r_rem[g+1]  <= 64'(n_rem2 - n_trial);
                r_root[g+1] <= {r_root[g][SQRT_BITS-2:0], 1'b1};
            end else begin
                r_rem[g+1]  <= n_rem2[63:0];
                r_root[g+1] <= {r_root[g][SQRT_BITS-2:0], 1'b0};
            end
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
        end
    end

    assign o_valid = r_vld[SQRT_BITS];
    assign o_root  = r_root[SQRT_BITS];
    assign o_side  = r_side[SQRT_BITS];
endmodule

[rtl/core/ocp_div.sv]
// Pipelined restoring divider for both coordinates, one quotient bit per stage
module ocp_div
    import ocp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [DIV_BITS-1:0]    i_num_x,
    input  logic [DIV_BITS-1:0]    i_num_y,
    input  logic [DEN_BITS-1:0]    i_den,
    input  logic [3:0]             i_tag,
    output logic                   o_valid,
    output logic [DIV_BITS-1:0]    o_quo_x,
    output logic [DIV_BITS-1:0]    o_quo_y,
    output logic [3:0]             o_tag
);
    logic [DIV_BITS:0]     r_vld;
    logic [DEN_BITS-1:0]   r_remx [DIV_BITS+1];
    logic [DEN_BITS-1:0]   r_remy [DIV_BITS+1];
    logic [DIV_BITS-1:0]   r_qx   [DIV_BITS+1];
    logic [DIV_BITS-1:0]   r_qy   [DIV_BITS+1];
    logic [DEN_BITS-1:0]   r_den  [DIV_BITS+1];
    logic [3:0]            r_tag  [DIV_BITS+1];

    // Load operands; numerators shift out of the quotient register
    always_ff @(posedge i_clk) begin
        r_remx[0] <= '0;
        r_remy[0] <= '0;
        r_qx[0]   <= i_num_x;
        r_qy[0]   <= i_num_y;
        r_den[0]  <= i_den;
        r_tag[0]  <= i_tag;
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    for (genvar g = 0; g < DIV_BITS; g++) begin : g_stage
        logic [DEN_BITS:0] n_tx;
        logic [DEN_BITS:0] n_ty;
        always_comb begin
            n_tx = {r_remx[g], r_qx[g][DIV_BITS-1]};
            n_ty = {r_remy[g], r_qy[g][DIV_BITS-1]};
        end
        always_ff @(posedge i_clk) begin
            r_den[g+1] <= r_den[g];
            r_tag[g+1] <= r_tag[g];
            if (n_tx >= {1'b0, r_den[g]}) begin
                r_remx[g+1] <= DEN_BITS'(n_tx - {1'b0, r_den[g]});
                r_qx[g+1]   <= {r_qx[g][DIV_BITS-2:0], 1'b1};
            end else begin
                r_remx[g+1] <= n_tx[DEN_BITS-1:0];
                r_qx[g+1]   <= {r_qx[g][DIV_BITS-2:0], 1'b0};
            end
            if (n_ty >= {1'b0, r_den[g]}) begin
                r_remy[g+1] <= DEN_BITS'(n_ty - {1'b0, r_den[g]});
                r_qy[g+1]   <= {r_qy[g][DIV_BITS-2:0], 1'b1};
            end else begin
                r_remy[g+1] <= n_ty[DEN_BITS-1:0];
                r_qy[g+1]   <= {r_qy[g][DIV_BITS-2:0], 1'b0};
            end
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
        end
    end

    assign o_valid = r_vld[DIV_BITS];
    assign o_quo_x = r_qx[DIV_BITS];
    assign o_quo_y = r_qy[DIV_BITS];
    assign o_tag   = r_tag[DIV_BITS];
endmodule

[rtl/core/ocp_distort.sv]
// Distortion, focal scaling and pixel checks, at most one multiplier level per stage
module ocp_distort
    import ocp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_valid,
    input  logic signed [31:0]  i_mx,
    input  logic signed [31:0]  i_my,
    input  t_flags              i_flags,
    output logic                o_valid,
    output logic signed [31:0]  o_u,
    output logic signed [31:0]  o_v,
    output logic                o_front,
    output logic                o_image
);
    localparam logic signed [33:0] U_MAX = 34'(IMAGE_WIDTH - 1) <<< 16;
    localparam logic signed [33:0] V_MAX = 34'(IMAGE_HEIGHT - 1) <<< 16;

    logic [DIST_STAGES-1:0] r_vld;
    t_flags r_fl [DIST_STAGES];

    // Stage registers
    logic signed [31:0] r_mx1, r_my1, r_mx2, r_my2, r_mxy2, r_mxd2, r_myd2;
    logic signed [31:0] r_mx3, r_my3, r_mx23, r_my23, r_mxy3, r_r2_3;
    logic signed [31:0] r_mx4, r_my4, r_mxy4, r_r2_4, r_tx4, r_ty4, r_k1r4, r_k2r4;
    logic signed [31:0] r_mx5, r_my5, r_r2_5, r_k1r5, r_k2r5;
    logic signed [31:0] r_pxy5, r_qxy5, r_ptx5, r_qty5;
    logic signed [31:0] r_mx6, r_my6, r_pxy6, r_qxy6, r_ptx6, r_qty6, r_rad6;
    logic signed [31:0] r_mx7, r_my7, r_pxy7, r_qxy7, r_ptx7, r_qty7, r_mrx7, r_mry7;
    logic signed [31:0] r_px8, r_py8;
    logic signed [63:0] r_fu9, r_fv9;
    logic signed [40:0] r_u10, r_v10;
    logic signed [31:0] r_u11, r_v11;
    logic               r_hit11;
    logic signed [31:0] r_u, r_v;
    logic               r_img;

    always_ff @(posedge i_clk) begin
        // Hold the input point
        r_mx1 <= i_mx;
        r_my1 <= i_my;
        // Square and cross terms
        r_mx2  <= qmul_sat(64'(r_mx1 * r_mx1));
        r_my2  <= qmul_sat(64'(r_my1 * r_my1));
        r_mxy2 <= qmul_sat(64'(r_mx1 * r_my1));
        r_mxd2 <= r_mx1;
        r_myd2 <= r_my1;
        r_mx3  <= r_mxd2;
        r_my3  <= r_myd2;
        // r2, the tangential radii and the k1, k2 products
        r_r2_3 <= sat32(66'(r_mx2) + 66'(r_my2));
        r_mx23 <= r_mx2;
        r_my23 <= r_my2;
        r_mxy3 <= r_mxy2;
        r_mx4  <= r_mx3;
        r_my4  <= r_my3;
        r_mxy4 <= r_mxy3;
        r_r2_4 <= r_r2_3;
        r_tx4  <= sat32(66'(r_r2_3) + 66'(r_mx23) + 66'(r_mx23));
        r_ty4  <= sat32(66'(r_r2_3) + 66'(r_my23) + 66'(r_my23));
        r_k1r4 <= qmul_sat(64'(i_cfg.k1 * r_r2_3));
        r_k2r4 <= qmul_sat(64'(i_cfg.k2 * r_r2_3));
        // Tangential products and k2*r2*r2
        r_mx5  <= r_mx4;
        r_my5  <= r_my4;
        r_r2_5 <= r_r2_4;
        r_k1r5 <= r_k1r4;
        r_k2r5 <= qmul_sat(64'(r_k2r4 * r_r2_4));
        r_pxy5 <= qmul_sat(64'(i_cfg.p1 * r_mxy4));
        r_qxy5 <= qmul_sat(64'(i_cfg.p2 * r_mxy4));
        r_ptx5 <= qmul_sat(64'(i_cfg.p2 * r_tx4));
        r_qty5 <= qmul_sat(64'(i_cfg.p1 * r_ty4));
        // Radial factor
        r_rad6 <= sat32(66'(r_k1r5) + 66'(r_k2r5));
        r_mx6  <= r_mx5;
        r_my6  <= r_my5;
        r_pxy6 <= r_pxy5;
        r_qxy6 <= r_qxy5;
        r_ptx6 <= r_ptx5;
        r_qty6 <= r_qty5;
        // Radial products
        r_mrx7 <= qmul_sat(64'(r_mx6 * r_rad6));
        r_mry7 <= qmul_sat(64'(r_my6 * r_rad6));
        r_mx7  <= r_mx6;
        r_my7  <= r_my6;
        r_pxy7 <= r_pxy6;
        r_qxy7 <= r_qxy6;
        r_ptx7 <= r_ptx6;
        r_qty7 <= r_qty6;
        // Distorted coordinates
        r_px8 <= sat32(66'(r_mx7) + 66'(r_mrx7) + 66'(r_pxy7) + 66'(r_pxy7) + 66'(r_ptx7));
        r_py8 <= sat32(66'(r_my7) + 66'(r_mry7) + 66'(r_qxy7) + 66'(r_qxy7) + 66'(r_qty7));
        // Focal scaling
        r_fu9 <= $signed({1'b0, i_cfg.focal_x}) * r_px8;
        r_fv9 <= $signed({1'b0, i_cfg.focal_y}) * r_py8;
        // Principal point
        r_u10 <= 41'(r_fu9 >>> 24) + $signed({9'b0, i_cfg.center_x});
        r_v10 <= 41'(r_fv9 >>> 24) + $signed({9'b0, i_cfg.center_y});
        // Saturate and note clamping
        r_u11   <= sat32(66'(r_u10));
        r_v11   <= sat32(66'(r_v10));
        r_hit11 <= (r_u10 != 41'(sat32(66'(r_u10)))) || (r_v10 != 41'(sat32(66'(r_v10))));
        // Apply special cases and image bounds
        if (r_fl[DIST_STAGES-2].behind) begin
            r_u   <= '0;
            r_v   <= '0;
            r_img <= 1'b0;
        end else if (r_fl[DIST_STAGES-2].zero_den) begin
            r_u   <= r_fl[DIST_STAGES-2].sgn_x ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            r_v   <= r_fl[DIST_STAGES-2].sgn_y ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            r_img <= 1'b0;
        end else begin
            r_u   <= r_u11;
            r_v   <= r_v11;
            r_img <= !r_hit11 && !r_u11[31] && !r_v11[31]
                && (34'(r_u11) <= U_MAX) && (34'(r_v11) <= V_MAX);
        end
    end

    // Valid bits and flags travel with the data
    always_ff @(posedge i_clk) begin
        r_fl[0] <= i_flags;
        for (int i = 1; i < DIST_STAGES; i++) begin
            r_fl[i] <= r_fl[i-1];
        end
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DIST_STAGES-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[DIST_STAGES-1];
    assign o_u     = r_u;
    assign o_v     = r_v;
    assign o_front = !r_fl[DIST_STAGES-1].behind;
    assign o_image = r_img;
endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ocp_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic               front;
        logic               image;
    } t_pixel_word;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [63:0]        i_cfg_data;
    logic signed [31:0] i_point_x;
    logic signed [31:0] i_point_y;
    logic signed [31:0] i_point_z;
    logic               o_done;
    logic signed [31:0] o_pixel_u;
    logic signed [31:0] o_pixel_v;
    logic               o_in_front;
    logic               o_in_image;

    // Camera settings as the block should hold them
    longint unsigned cam_fx, cam_fy, cam_cx, cam_cy;
    longint          cam_xi, cam_k1, cam_k2, cam_p1, cam_p2;

    t_pixel_word pixel_queue[$];
    int          mismatch_cnt;
    int          idle_cycles;

    omni_camera_point_projection u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_point_z   (i_point_z),
        .o_done      (o_done),
        .o_pixel_u   (o_pixel_u),
        .o_pixel_v   (o_pixel_v),
        .o_in_front  (o_in_front),
        .o_in_image  (o_in_image)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic longint clip32(longint val);
        if (val > 64'sd2147483647) return 64'sd2147483647;
        if (val < -64'sd2147483648) return -64'sd2147483648;
        return val;
    endfunction

    // Q8.24 product, floored, clipped
    function automatic longint fix_mul(longint a, longint b);
        longint prod;
        prod = a * b;
        return clip32(prod >>> 24);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned val);
        longint unsigned root;
        longint unsigned bitpos;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > val) bitpos = bitpos >> 2;
        while (bitpos != 0) begin
            if (val >= root + bitpos) begin
                val = val - (root + bitpos);
                root = (root >> 1) + bitpos;
            end else begin
                root = root >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    // Project one point with the current camera settings
    function automatic t_pixel_word project_point(logic signed [31:0] px, logic signed [31:0] py,
                                                  logic signed [31:0] pz);
        t_pixel_word     w;
        longint          x, y, z, den, mx, my, mx2, my2, mxy, r2, rad, dx, dy;
        longint          su, sv;
        longint unsigned sq;
        bit              clipped;
        x = px;
        y = py;
        z = pz;
        w.u = '0;
        w.v = '0;
        w.front = 1'b0;
        w.image = 1'b0;
        if (z < 0) return w;
        w.front = 1'b1;
        sq = longint'(x * x) + longint'(y * y) + longint'(z * z);
        den = z + ((cam_xi * longint'(int_sqrt(sq))) >>> 24);
        if (den == 0) begin
            w.u = (x >= 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            w.v = (y >= 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            return w;
        end
        mx = clip32((x <<< 24) / den);
        my = clip32((y <<< 24) / den);
        mx2 = fix_mul(mx, mx);
        my2 = fix_mul(my, my);
        mxy = fix_mul(mx, my);
        r2 = clip32(mx2 + my2);
        rad = clip32(fix_mul(cam_k1, r2) + fix_mul(fix_mul(cam_k2, r2), r2));
        dx = clip32(mx + fix_mul(mx, rad) + 2 * fix_mul(cam_p1, mxy)
                    + fix_mul(cam_p2, clip32(r2 + 2 * mx2)));
        dy = clip32(my + fix_mul(my, rad) + 2 * fix_mul(cam_p2, mxy)
                    + fix_mul(cam_p1, clip32(r2 + 2 * my2)));
        su = ((longint'(cam_fx) * dx) >>> 24) + longint'(cam_cx);
        sv = ((longint'(cam_fy) * dy) >>> 24) + longint'(cam_cy);
        clipped = (clip32(su) != su) || (clip32(sv) != sv);
        su = clip32(su);
        sv = clip32(sv);
        w.u = su[31:0];
        w.v = sv[31:0];
        w.image = !clipped && su >= 0 && sv >= 0 && su <= longint'(IMAGE_WIDTH - 1) * 65536
                  && sv <= longint'(IMAGE_HEIGHT - 1) * 65536;
        return w;
    endfunction

    // Send one point and hold until the block takes it
    task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
                              logic signed [31:0] pz);
        start <= 1'b1;
        i_point_x <= px;
        i_point_y <= py;
        i_point_z <= pz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pixel_queue.push_back(project_point(px, py, pz));
    endtask

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Let the pipeline empty out before touching the settings
    task automatic drain_pipeline();
        start <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Drive one register write; the caller drops the write enable
    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_FOCAL_X:    cam_fx = data[31:0];
            REG_FOCAL_Y:    cam_fy = data[31:0];
            REG_CENTER_X:   cam_cx = data[31:0];
            REG_CENTER_Y:   cam_cy = data[31:0];
            REG_MIRROR_XI:  cam_xi = longint'(signed'(data[31:0]));
            REG_RADIAL_K1:  cam_k1 = longint'(signed'(data[31:0]));
            REG_RADIAL_K2:  cam_k2 = longint'(signed'(data[31:0]));
            REG_TANGENTIAL: begin
                cam_p1 = longint'(signed'(data[31:0]));
                cam_p2 = longint'(signed'(data[63:32]));
            end
            default: ;
        endcase
    endtask

    task automatic load_camera(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
                               logic [31:0] cy, logic [31:0] xi, logic [31:0] k1,
                               logic [31:0] k2, logic [63:0] tang);
        write_reg(REG_FOCAL_X, {32'd0, fx});
        write_reg(REG_FOCAL_Y, {32'd0, fy});
        write_reg(REG_CENTER_X, {32'd0, cx});
        write_reg(REG_CENTER_Y, {32'd0, cy});
        write_reg(REG_MIRROR_XI, {32'd0, xi});
        write_reg(REG_RADIAL_K1, {32'd0, k1});
        write_reg(REG_RADIAL_K2, {32'd0, k2});
        write_reg(REG_TANGENTIAL, tang);
        i_cfg_we <= 1'b0;
    endtask

    // Extremes, behind camera, zero denominator, clipped pixel
    task automatic test_corner_points();
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh8000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1);
        send_point(32'sh0001_0000, -32'sh0002_0000, 32'sd0);
        send_point(-32'sd1, 32'sd0, 32'sd0);
        send_point(32'sd0, 32'sd0, 32'sd0);
        send_point(32'sh0000_8000, -32'sh0000_4000, 32'sh0001_0000);
        send_point(32'sh7FFF_FFFF, 32'sd1, 32'sd1);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1);
        send_point(32'sh0010_0000, 32'sh0020_0000, 32'sh0040_0000);
        pause_sender(3);
        drain_pipeline();
    endtask

    // Negative xi brings the denominator to zero and below
    task automatic test_negative_mirror();
        load_camera(32'h012C_0000, 32'h012C_0000, 32'h0200_0000, 32'h0200_0000,
                    -32'sh0100_0000, 32'h0010_0000, -32'sh0004_0000,
                    {32'hFFF0_0000, 32'h0008_0000});
        send_point(32'sd0, 32'sd0, 32'sh0005_0000);
        send_point(32'sd0, 32'sd0, 32'sh7FFF_FFFF);
        send_point(32'sh0003_0000, 32'sh0004_0000, 32'sh0001_0000);
        send_point(-32'sh0003_0000, 32'sh0004_0000, 32'sh0001_0000);
        drain_pipeline();
    endtask

    function automatic logic [31:0] rand_word();
        return $urandom();
    endfunction

    // Mostly plausible points; some raw noise and some behind the camera
    task automatic send_random_point();
        int                 mode;
        logic signed [31:0] z, span;
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
            send_point(rand_word(), rand_word(), rand_word());
        end else if (mode == 2) begin
            z = -$signed({1'b0, rand_word() & 32'h7FFF_FFFF}) - 1;
            send_point(rand_word(), rand_word(), z);
        end else begin
            z = $urandom_range(32'h0000_1000, 32'h0064_0000);
            span = z;
            send_point($signed($urandom_range(0, 2 * span)) - span,
                       $signed($urandom_range(0, 2 * span)) - span, z);
        end
    endtask

    // Bursts of random length, most followed by a random gap
    task automatic run_random_points(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                send_random_point();
                sent++;
            end
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
        end
        drain_pipeline();
    endtask

    task automatic test_random_settings();
        // Reset settings, a typical lens, register extremes, a second lens, then random settings
        run_random_points(300);
        load_camera(32'h01F4_0000, 32'h01E0_0000, 32'h0200_0000, 32'h01F0_0000,
                    32'h00C0_0000, -32'sh0040_0000, 32'h0008_0000,
                    {32'h0000_4000, 32'hFFFF_C000});
        run_random_points(500);
        load_camera(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF);
        run_random_points(200);
        load_camera(32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 64'h8000_0000_8000_0000);
        run_random_points(200);
        load_camera(32'h0100_0000, 32'h0120_0000, 32'h0180_0000, 32'h0190_0000,
                    32'h0080_0000, 32'h0002_0000, -32'sh0001_0000,
                    {32'hFFFF_F000, 32'h0000_1000});
        run_random_points(500);
        repeat (8) begin
            load_camera(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                        rand_word(), rand_word(), {rand_word(), rand_word()});
            run_random_points(40);
        end
    endtask

    // Compare each result word with the oldest expected one
    always @(posedge i_clk) begin
        t_pixel_word want;
        if (i_rst_n && o_done) begin
            if (pixel_queue.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result word u=%h v=%h",
                                                 o_pixel_u, o_pixel_v);
            end else begin
                want = pixel_queue.pop_front();
                if (o_pixel_u !== want.u || o_pixel_v !== want.v
                        || o_in_front !== want.front || o_in_image !== want.image) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp u=%h v=%h f=%b i=%b got u=%h v=%h f=%b i=%b",
                                 want.u, want.v, want.front, want.image,
                                 o_pixel_u, o_pixel_v, o_in_front, o_in_image);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("omni_camera_point_projection verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        mismatch_cnt = 0;
        idle_cycles = 0;
        cam_fx = 65536;
        cam_fy = 65536;
        cam_cx = 0;
        cam_cy = 0;
        cam_xi = 0;
        cam_k1 = 0;
        cam_k2 = 0;
        cam_p1 = 0;
        cam_p2 = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_point_x = '0;
        i_point_y = '0;
        i_point_z = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_points();
        test_negative_mirror();
        test_random_settings();
        drain_pipeline();
        if (mismatch_cnt == 0 && pixel_queue.size() == 0) begin
            $display("omni_camera_point_projection verification clean");
        end else begin
            $display("omni_camera_point_projection verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/ocp_pkg.sv
rtl/core/ocp_sqrt.sv
rtl/core/ocp_div.sv
rtl/core/ocp_distort.sv
rtl/core/omni_camera_point_projection.sv
test/tb_top.sv
